// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lrp_pkg.sv =====
package lrp_pkg;

    // Field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int STEP_CFG_W = 19;
    localparam int GAIN_W     = 18;
    localparam int CFG_DATA_W = 19;
    localparam int GAIN_FRAC  = 16;

    // Register reset values and step clamp range (Q16)
    localparam logic [STEP_CFG_W-1:0] STEP_RESET = 19'd65536;
    localparam logic [GAIN_W-1:0]     GAIN_RESET = 18'd65536;
    localparam logic [STEP_CFG_W-1:0] STEP_MIN   = 19'd16384;
    localparam logic [STEP_CFG_W-1:0] STEP_MAX   = 19'd262144;

    // Results per input word are capped
    localparam logic [3:0] MAX_RESULTS = 4'd8;

    // int16 saturation magnitudes
    localparam int SAT_POS_MAG = 32767;
    localparam int SAT_NEG_MAG = 32768;
    localparam logic signed [SAMPLE_W-1:0] SAT_POS = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_NEG = 16'sh8000;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_STEP = 1'b0,
        CFG_GAIN = 1'b1
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_ACC,
        ST_RND,
        ST_GAIN,
        ST_NEXT
    } t_state;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in_sample;
        logic                       in_last;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_sample;
        logic                       run_end;
        logic                       stream_end;
    } t_out_word;

endpackage

// ===== hdl/linear_interp_pitch_resampler.sv =====
// Linear-interpolation pitch resampler. Input samples arrive one word at a
// time, the final one of a stream flagged by in_last; output positions step
// by step_q16 (clamped to 0.25..4.0) and each output is interpolated between
// the two neighboring samples, rounded, scaled by gain_q16 and saturated to
// int16. Up to eight output words follow one input word; run_end marks the
// last of them and stream_end the last of the stream. One shared multiplier
// does both the interpolation product and the gain product, so an input word
// keeps the input stalled while its outputs are worked out one by one (also
// through the closing interval when the final sample opens it), and while
// the output side stalls. An output word may wait in the output register
// while the next input word is already accepted. Config writes are taken at
// any time but must only happen while the block is idle.
module linear_interp_pitch_resampler #(
    parameter int LENGTH_BITS   = 24,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  lrp_pkg::t_in_word                   i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output lrp_pkg::t_out_word                  o_out_word,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  lrp_pkg::t_cfg_idx                   i_cfg_index,
    input  logic [lrp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import lrp_pkg::*;

    localparam int FB      = FRACTION_BITS;
    localparam int POS_W   = LENGTH_BITS + FRACTION_BITS;
    localparam int STEP_W  = FB + 3;
    localparam int MUL_B_W = ((FB > GAIN_W) ? FB : GAIN_W) + 1;
    localparam int MUL_A_W = SAMPLE_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = FB + SAMPLE_W + 2;
    localparam int SATQ_W  = PROD_W - GAIN_FRAC;
    localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FB - 1);

    // Config registers
    logic [STEP_CFG_W-1:0] r_step_cfg;
    logic [GAIN_W-1:0]     r_gain;

    // Stream state
    logic signed [SAMPLE_W-1:0] r_prev;
    logic [LENGTH_BITS-1:0]     r_cnt;
    logic [POS_W-1:0]           r_pos;

    // Per-word working registers
    t_state                     n_state;
    t_state                     r_state;
    logic signed [SAMPLE_W-1:0] r_a;
    logic signed [SAMPLE_W-1:0] r_b;
    logic                       r_last;
    logic                       r_ph1;
    logic [LENGTH_BITS-1:0]     r_base;
    logic [STEP_W-1:0]          r_step;
    logic [3:0]                 r_n;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [MUL_A_W-1:0]  r_val;

    // Output register
    logic      r_out_valid;
    t_out_word r_out_word;

    // Control
    logic accept;
    logic out_free;
    logic hit;
    logic more_phase;
    logic do_phase;
    logic do_emit;
    logic do_finish;
    logic sel_gain;

    // Datapath nets
    logic [POS_W-1:0]                  d_pos;
    logic [STEP_CFG_W-1:0]             step_clamp;
    logic [STEP_CFG_W+FB-1:0]          step_wide;
    logic signed [MUL_A_W-1:0]         diff;
    logic signed [MUL_A_W-1:0]         mul_a;
    logic signed [MUL_B_W-1:0]         mul_b;
    logic signed [PROD_W-1:0]          mul_p;
    logic [ACC_W-1:0]                  acc_base;
    logic                              rnd_neg;
    logic [ACC_W-1:0]                  rnd_mag;
    logic [ACC_W-1:0]                  rnd_sum;
    logic [MUL_A_W-1:0]                rnd_q;
    logic                              sat_neg;
    logic [PROD_W-1:0]                 sat_mag;
    logic [SATQ_W-1:0]                 sat_q;
    logic signed [SAMPLE_W-1:0]        sat_res;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Distance of the next position from the current interval base
    assign d_pos      = r_pos - {r_base, {FB{1'b0}}};
    assign hit        = (!r_ph1 || r_last) && (d_pos[POS_W-1:FB] == '0)
                        && (r_n != MAX_RESULTS);
    assign more_phase = !r_ph1 && r_last;

    // Clamped step rescaled from Q16 to the position format
    always_comb begin
        if (r_step_cfg < STEP_MIN) begin
            step_clamp = STEP_MIN;
        end else if (r_step_cfg > STEP_MAX) begin
            step_clamp = STEP_MAX;
        end else begin
            step_clamp = r_step_cfg;
        end
    end
    assign step_wide = {step_clamp, {FB{1'b0}}};

    // Shared multiplier: interpolation product, then gain product
    assign diff  = {r_b[SAMPLE_W-1], r_b} - {r_a[SAMPLE_W-1], r_a};
    assign mul_a = sel_gain ? r_val : diff;
    assign mul_b = sel_gain ? MUL_B_W'(r_gain) : MUL_B_W'(d_pos[FB-1:0]);
    assign mul_p = mul_a * mul_b;

    // a*ONE + (b-a)*f
    assign acc_base = {{(ACC_W-SAMPLE_W-FB){r_a[SAMPLE_W-1]}}, r_a, {FB{1'b0}}};

    // Round half away from zero
    assign rnd_neg = r_acc[ACC_W-1];
    assign rnd_mag = rnd_neg ? (ACC_W'(0) - r_acc) : r_acc;
    assign rnd_sum = rnd_mag + RND_HALF;
    assign rnd_q   = rnd_sum[FB+MUL_A_W-1:FB];

    // Truncate toward zero and saturate to int16
    assign sat_neg = r_prod[PROD_W-1];
    assign sat_mag = sat_neg ? (PROD_W'(0) - r_prod) : r_prod;
    assign sat_q   = sat_mag[PROD_W-1:GAIN_FRAC];
    always_comb begin
        if (sat_neg) begin
            sat_res = (sat_q > SATQ_W'(SAT_NEG_MAG)) ? SAT_NEG
                                                     : -sat_q[SAMPLE_W-1:0];
        end else begin
            sat_res = (sat_q > SATQ_W'(SAT_POS_MAG)) ? SAT_POS
                                                     : sat_q[SAMPLE_W-1:0];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    n_state = ST_MUL;
                end else if (!more_phase) begin
                    n_state = ST_IDLE;
                end
            end
            ST_MUL:  n_state = ST_ACC;
            ST_ACC:  n_state = ST_RND;
            ST_RND:  n_state = ST_GAIN;
            ST_GAIN: n_state = ST_NEXT;
            ST_NEXT: begin
                if (hit && out_free) begin
                    n_state = ST_MUL;
                end else if (!hit && !more_phase && out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        do_phase  = 1'b0;
        do_emit   = 1'b0;
        do_finish = 1'b0;
        sel_gain  = 1'b0;
        unique case (r_state)
            ST_SCAN: begin
                do_phase  = !hit && more_phase;
                do_finish = !hit && !more_phase;
            end
            ST_GAIN: begin
                sel_gain = 1'b1;
            end
            ST_NEXT: begin
                do_phase  = !hit && more_phase;
                do_emit   = (hit || !more_phase) && out_free;
                do_finish = !hit && !more_phase && out_free;
            end
            default: begin
                do_phase = 1'b0;
            end
        endcase
    end

    // Control and stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step_cfg  <= STEP_RESET;
            r_gain      <= GAIN_RESET;
            r_prev      <= '0;
            r_cnt       <= '0;
            r_pos       <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // Config write
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_STEP: r_step_cfg <= i_cfg_data;
                    CFG_GAIN: r_gain     <= i_cfg_data[GAIN_W-1:0];
                    default:  r_gain     <= r_gain;
                endcase
            end

            if (accept) begin
                r_n <= '0;
            end

            // Advance position after each result
            if (r_state == ST_GAIN) begin
                r_pos <= r_pos + POS_W'(r_step);
                r_n   <= r_n + 4'd1;
            end

            // Close out the input word
            if (do_finish) begin
                if (r_last) begin
                    r_prev <= '0;
                    r_cnt  <= '0;
                    r_pos  <= '0;
                end else begin
                    r_prev <= r_b;
                    r_cnt  <= r_cnt + LENGTH_BITS'(1);
                end
            end

            // Output register
            if (do_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers and datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b    <= i_in_word.in_sample;
            r_last <= i_in_word.in_last;
            r_step <= step_wide[STEP_CFG_W+FB-1:GAIN_FRAC];
            r_ph1  <= (r_cnt == '0);
            r_base <= (r_cnt == '0) ? r_cnt : (r_cnt - LENGTH_BITS'(1));
            r_a    <= (r_cnt == '0) ? i_in_word.in_sample : r_prev;
        end
        if (do_phase) begin
            r_ph1  <= 1'b1;
            r_base <= r_cnt;
        end
        if (r_state == ST_MUL || r_state == ST_GAIN) begin
            r_prod <= mul_p;
        end
        if (r_state == ST_ACC) begin
            r_acc <= acc_base + r_prod[ACC_W-1:0];
        end
        if (r_state == ST_RND) begin
            r_val <= rnd_neg ? (MUL_A_W'(0) - rnd_q) : rnd_q;
        end
        if (do_emit) begin
            r_out_word <= '{out_sample: sat_res, run_end: !hit,
                            stream_end: !hit && r_last};
        end
    end

endmodule

// ===== hdl/lrp_check.sv =====
`include "assert_macros.svh"

module lrp_check (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input lrp_pkg::t_out_word   o_out_word
);
    import lrp_pkg::*;

    // A stalled output word stays offered
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "output word dropped while stalled")

    // A stalled output word does not change
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_word), "output word changed while stalled")

    // An accepted input word makes the block busy
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input not stalled after accept")

    // Results are only launched while an input word is being worked on
    `ASSERT_SAME(a_emit_while_busy, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall), "output word launched while idle")

endmodule

bind linear_interp_pitch_resampler lrp_check u_lrp_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
